>>> src/table_linear_interpolator_assert.svh
// Assertion macros used by the checker file of the interpolator.
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define TLI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tli assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tli assertion failed");

`endif

>>> src/tli_pkg.sv
`timescale 1ns / 1ps

package tli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 9;
    localparam int ENERGY_W    = 40;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int QUO_W       = 32;
    localparam int DIV_CNT_W   = $clog2(QUO_W);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_EXACT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INTERP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_MUL0  = 8'b0000_0100,
        S_MUL1  = 8'b0000_1000,
        S_DINIT = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_FIX   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic wr;
        logic start;
        logic scan;
        logic mul0;
        logic mul1;
        logic dinit;
        logic div;
        logic fix;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic interp;
        logic div_last;
    } t_sts;

endpackage

>>> src/tli_if.sv
`timescale 1ns / 1ps

interface tli_req_if import tli_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SLOT_W-1:0]   point_index;
    logic [ENERGY_W-1:0] point_energy;
    logic [VALUE_W-1:0]  point_value;
    logic [ENERGY_W-1:0] query_energy;

    modport source (output valid, req_type, point_index, point_energy, point_value,
                    query_energy, input ready);
    modport sink (input valid, req_type, point_index, point_energy, point_value,
                  query_energy, output ready);
endinterface

interface tli_rsp_if import tli_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] result_status;
    logic [SLOT_W-1:0]   upper_slot;

    modport source (output valid, result_value, result_status, upper_slot, input ready);
    modport sink (input valid, result_value, result_status, upper_slot, output ready);
endinterface

>>> src/tli_ctrl.sv
`timescale 1ns / 1ps

module tli_ctrl import tli_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_type,
    output logic o_req_ready,
    input  logic i_rsp_ready,
    output logic o_rsp_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   accept;

    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_rsp_valid = r_out_vld;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr    = accept && (i_req_type == REQ_WRITE);
                o_cmd.start = accept && (i_req_type == REQ_QUERY);
                if (accept && (i_req_type == REQ_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = i_sts.interp ? S_MUL0 : S_DONE;
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_rsp_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

>>> src/tli_datapath.sv
`timescale 1ns / 1ps

module tli_datapath import tli_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_cfg_we,
    input  logic [CNT_W-1:0]    i_cfg_wdata,
    input  logic [SLOT_W-1:0]   i_point_index,
    input  logic [ENERGY_W-1:0] i_point_energy,
    input  logic [VALUE_W-1:0]  i_point_value,
    input  logic [ENERGY_W-1:0] i_query_energy,
    output logic [VALUE_W-1:0]  o_result_value,
    output logic [STATUS_W-1:0] o_result_status,
    output logic [SLOT_W-1:0]   o_upper_slot
);

    logic [ENERGY_W-1:0] mem_energy [TABLE_DEPTH];
    logic [VALUE_W-1:0]  mem_value  [TABLE_DEPTH];

    logic [CNT_W-1:0]     r_piu;
    logic [CNT_W-1:0]     n_eff;
    logic [CNT_W-1:0]     last_idx;
    logic [ENERGY_W-1:0]  r_q;
    logic [CNT_W-1:0]     r_rd_addr;
    logic [CNT_W-1:0]     r_dat_idx;
    logic                 r_rd_vld;
    logic [ENERGY_W-1:0]  r_e_rd;
    logic [VALUE_W-1:0]   r_v_rd;
    logic [ENERGY_W-1:0]  r_prev_e;
    logic [VALUE_W-1:0]   r_prev_v;
    logic [VALUE_W-1:0]   r_lo_v;
    logic                 r_neg;
    logic [VALUE_W-1:0]   r_m;
    logic [ENERGY_W-1:0]  r_dx;
    logic [ENERGY_W-1:0]  r_den;
    logic [63:0]          r_p0;
    logic [ENERGY_W-1:0]  r_p1;
    logic [ENERGY_W-1:0]  r_rem;
    logic [QUO_W-1:0]     r_low;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [VALUE_W-1:0]   r_val;
    logic [STATUS_W-1:0]  r_status;
    logic [SLOT_W-1:0]    r_slot;
    logic [VALUE_W-1:0]   r_o_value;
    logic [STATUS_W-1:0]  r_o_status;
    logic [SLOT_W-1:0]    r_o_slot;

    logic                rd_issue;
    logic                ge;
    logic                eq;
    logic                found_hit;
    logic                found_end;
    logic                v_neg;
    logic [ENERGY_W:0]   div_t;
    logic [ENERGY_W:0]   div_diff;
    logic                div_ge;

    always_comb begin
        if (r_piu == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_piu > CNT_W'(TABLE_DEPTH)) begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end else begin
            n_eff = r_piu;
        end
    end

    assign last_idx  = n_eff - CNT_W'(1);
    assign rd_issue  = i_cmd.scan && (r_rd_addr < n_eff);
    assign ge        = (r_e_rd >= r_q);
    assign eq        = (r_e_rd == r_q);
    assign found_hit = i_cmd.scan && r_rd_vld && ge;
    assign found_end = i_cmd.scan && r_rd_vld && !ge && (r_dat_idx == last_idx);
    assign v_neg     = (r_v_rd < r_prev_v);

    assign div_t    = {r_rem, r_low[QUO_W-1]};
    assign div_diff = div_t - {1'b0, r_den};
    assign div_ge   = (div_t >= {1'b0, r_den});

    assign o_sts.found    = found_hit || found_end;
    assign o_sts.interp   = found_hit && !eq && (r_dat_idx != '0);
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(QUO_W - 1));

    assign o_result_value  = r_o_value;
    assign o_result_status = r_o_status;
    assign o_upper_slot    = r_o_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem_energy[i_point_index] <= i_point_energy;
            mem_value[i_point_index]  <= i_point_value;
        end
        if (rd_issue) begin
            r_e_rd <= mem_energy[r_rd_addr[SLOT_W-1:0]];
            r_v_rd <= mem_value[r_rd_addr[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu     <= CNT_W'(1);
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_piu <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_rd_addr <= '0;
                r_rd_vld  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= rd_issue;
                if (rd_issue) begin
                    r_rd_addr <= r_rd_addr + CNT_W'(1);
                end
            end
            if (i_cmd.dinit) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q <= i_query_energy;
        end
        if (rd_issue) begin
            r_dat_idx <= r_rd_addr;
        end
        if (i_cmd.scan && r_rd_vld && !ge) begin
            r_prev_e <= r_e_rd;
            r_prev_v <= r_v_rd;
        end
        if (found_hit || found_end) begin
            r_slot <= r_dat_idx[SLOT_W-1:0];
            r_val  <= r_v_rd;
            if (found_end) begin
                r_status <= ST_ABOVE;
            end else if (eq) begin
                r_status <= ST_EXACT;
            end else if (r_dat_idx == '0) begin
                r_status <= ST_BELOW;
            end else begin
                r_status <= ST_INTERP;
            end
            r_lo_v <= r_prev_v;
            r_neg  <= v_neg;
            r_m    <= v_neg ? (r_prev_v - r_v_rd) : (r_v_rd - r_prev_v);
            r_dx   <= r_q - r_prev_e;
            r_den  <= r_e_rd - r_prev_e;
        end
        if (i_cmd.mul0) begin
            r_p0 <= {32'd0, r_m} * {32'd0, r_dx[31:0]};
        end
        if (i_cmd.mul1) begin
            r_p1 <= {8'd0, r_m} * {32'd0, r_dx[ENERGY_W-1:32]};
        end
        if (i_cmd.dinit) begin
            r_rem <= {8'd0, r_p0[63:32]} + r_p1;
            r_low <= r_p0[31:0];
            r_quo <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= div_ge ? div_diff[ENERGY_W-1:0] : div_t[ENERGY_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
            r_low <= {r_low[QUO_W-2:0], 1'b0};
        end
        if (i_cmd.fix) begin
            r_val <= r_neg ? (r_lo_v - r_quo) : (r_lo_v + r_quo);
        end
        if (i_cmd.load_out) begin
            r_o_value  <= r_val;
            r_o_status <= r_status;
            r_o_slot   <= r_slot;
        end
    end

endmodule

>>> src/table_linear_interpolator.sv
`timescale 1ns / 1ps
// Piecewise-linear table interpolator with a 256-point table.
// Request channel i_req: req_type 0 writes point_energy and point_value into slot
// point_index; req_type 1 queries query_energy. Response channel o_rsp carries
// result_value (Q16.16), result_status and upper_slot, one beat per query only.
// The points_in_use register is written through i_cfg_we and i_cfg_wdata. The user
// must write it only while idle; the block itself does not enforce this. Write beats
// complete as they are accepted, so they can follow back to back. A query scans slots
// upward from slot 0, one memory read per cycle, and stops at slot h (the last slot in
// use when the query is above the table). An exact, above-table or below-table result
// skips interpolation. An interpolated one first passes through the multiply states
// MUL0 and MUL1, a setup state, a 32-bit restoring divide and a correction state.
// The block handles one query at a time and is ready again as the result loads.
// It accepts new beats while a result waits. If the receiver stalls, the result beat
// holds and a finished query waits for the output register to free before the block
// becomes ready again.
// Reset sets points_in_use to one and empties the output register; ready stays low
// while reset is held. Table contents are not cleared and must be written before
// they are queried.
module table_linear_interpolator import tli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tli_req_if.sink          i_req,
    tli_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    tli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tli_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_point_index   (i_req.point_index),
        .i_point_energy  (i_req.point_energy),
        .i_point_value   (i_req.point_value),
        .i_query_energy  (i_req.query_energy),
        .o_result_value  (o_rsp.result_value),
        .o_result_status (o_rsp.result_status),
        .o_upper_slot    (o_rsp.upper_slot)
    );

endmodule

>>> src/tli_checker.sv
`timescale 1ns / 1ps
`include "table_linear_interpolator_assert.svh"

module tli_checker import tli_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_req_type,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_rsp_status,
    input logic [SLOT_W-1:0]   i_rsp_slot
);

    logic query_acc;

    assign query_acc = i_req_valid && i_req_ready && (i_req_type == REQ_QUERY);

    `TLI_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `TLI_ASSERT_SAME(a_below_slot, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == ST_BELOW), i_rsp_slot == '0)
    `TLI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, query_acc, !i_req_ready)
    `TLI_ASSERT_NEXT(a_no_early_rsp, i_clk, i_rst_n, query_acc, !$rose(i_rsp_valid))

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.result_status),
    .i_rsp_slot   (o_rsp.upper_slot)
);
